// ===== rtl/score_table_rank_select_core_defines.svh =====
// ----------------------------------------------------------------------------
// Score table rank select: assertion macros
// Shared assertion forms for the checker of the core.
// ----------------------------------------------------------------------------
`ifndef SCORE_TABLE_RANK_SELECT_CORE_DEFINES_SVH
`define SCORE_TABLE_RANK_SELECT_CORE_DEFINES_SVH

// clocked assertion, off while reset is held
`define STSEL_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("stsel: assertion failed");

// clocked assertion, live through reset
`define STSEL_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("stsel: reset assertion failed");

`endif

// ===== rtl/stsel_pkg.sv =====
// ----------------------------------------------------------------------------
// Score table rank select: package
// Table size, field widths and command codes.
// ----------------------------------------------------------------------------
package stsel_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SCORE_W     = 14;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 14'd9999;

    localparam int CFG_W       = 7;
    localparam int ENTRY_W     = 6;
    localparam int RANK_W      = 7;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 8;

    typedef enum logic [1:0] {
        CMD_INC   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

endpackage

// ===== rtl/score_table_rank_select_core.sv =====
// ----------------------------------------------------------------------------
// Score table rank select: core
// Two saturating score counters per entry with rank queries over the table.
// ----------------------------------------------------------------------------
// An increment passes through S_INC and S_FIN to the output register, a clear
// through S_FIN alone. A rank query with rank R runs R rounds of the scan
// (none for rank 0, and a round ends at once when no entry is in use): each
// round reads every entry in use once from the score RAM, one read a cycle,
// and ends early on an entry equal to its reference. Scores clear through
// per-entry valid flags, so reset and clear need no sweep of the RAM. One
// command is worked at a time; the next input beat is taken while a finished
// result still waits in the output register.
module score_table_rank_select_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stsel_pkg::CFG_W-1:0]   i_cfg_wdata,     // entries_in_use
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [stsel_pkg::S_TDATA_W-1:0] i_s_tdata,     // entry_index, rank_wanted, pad
    input  logic [stsel_pkg::S_TUSER_W-1:0] i_s_tuser,     // command, score_select
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [stsel_pkg::M_TDATA_W-1:0] o_m_tdata,     // ranked_index, pad
    output logic                          o_m_tuser        // was_query
);

    import stsel_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INC,
        S_SCAN,
        S_FIN
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [TABLE_DEPTH-1:0] r_va;
    logic [TABLE_DEPTH-1:0] r_vb;
    logic [TABLE_DEPTH-1:0] r_marks;

    logic                 r_sel;
    logic                 r_inc_ok;
    logic [IDX_W-1:0]     r_pidx;
    logic                 r_pv;
    logic [CNT_W-1:0]     r_rd_idx;
    logic [RANK_W-1:0]    r_rank;
    logic [RANK_W-1:0]    r_round;
    logic [SCORE_W-1:0]   r_ref;
    logic                 r_ref_ok;
    logic [SCORE_W-1:0]   r_best;
    logic [IDX_W-1:0]     r_best_idx;
    logic                 r_has_best;
    logic [ENTRY_W-1:0]   r_res_idx;
    logic                 r_res_q;

    logic                 r_ovalid;
    logic [ENTRY_W-1:0]   r_oidx;
    logic                 r_oq;

    logic [CNT_W-1:0]     used_n;
    logic                 accept;
    t_cmd                 in_cmd;
    logic [ENTRY_W-1:0]   in_idx;
    logic [RANK_W-1:0]    in_rank;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [SCORE_W-1:0]   rd_a;
    logic [SCORE_W-1:0]   rd_b;
    logic [SCORE_W-1:0]   cur_s;
    logic [SCORE_W-1:0]   n_score;
    logic                 inc_do;
    logic                 we_a;
    logic                 we_b;
    logic                 cand;
    logic                 hit;
    logic                 issue;
    logic                 end_round;
    logic [IDX_W-1:0]     win;
    logic [RANK_W-1:0]    n_round;
    logic                 out_free;

    assign in_cmd  = t_cmd'(i_s_tuser[1:0]);
    assign in_idx  = i_s_tdata[ENTRY_W-1:0];
    assign in_rank = i_s_tdata[ENTRY_W+RANK_W-1:ENTRY_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;

    always_comb begin
        if (32'(r_cfg) > TABLE_DEPTH) begin
            used_n = CNT_W'(TABLE_DEPTH);
        end else begin
            used_n = CNT_W'(r_cfg);
        end
    end

    // score of the entry whose read data is back
    always_comb begin
        if (r_sel) begin
            cur_s = r_vb[r_pidx] ? rd_b : '0;
        end else begin
            cur_s = r_va[r_pidx] ? rd_a : '0;
        end
    end

    assign n_score = cur_s + SCORE_W'(1);
    assign inc_do  = (r_state == S_INC) && r_inc_ok && (cur_s < SCORE_MAX);
    assign we_a    = inc_do && !r_sel;
    assign we_b    = inc_do && r_sel;

    assign issue     = (r_state == S_SCAN) && (r_rd_idx < used_n);
    assign cand      = r_pv && !r_marks[r_pidx];
    assign hit       = cand && r_ref_ok && (cur_s == r_ref);
    assign end_round = hit || (!r_pv && !issue);
    assign n_round   = r_round + RANK_W'(1);

    always_comb begin
        if (hit) begin
            win = r_pidx;
        end else if (r_has_best) begin
            win = r_best_idx;
        end else begin
            win = '0;
        end
    end

    always_comb begin
        if (r_state == S_SCAN) begin
            rd_en   = issue;
            rd_addr = r_rd_idx[IDX_W-1:0];
        end else begin
            rd_en   = accept && (in_cmd == CMD_INC);
            rd_addr = IDX_W'(in_idx);
        end
    end

    stsel_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(SCORE_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_pidx),
        .i_wdata (n_score),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_a)
    );

    stsel_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(SCORE_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_pidx),
        .i_wdata (n_score),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= '0;
            r_va     <= '0;
            r_vb     <= '0;
            r_marks  <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (r_ovalid && i_m_tready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sel     <= i_s_tuser[2];
                        r_pidx    <= IDX_W'(in_idx);
                        r_inc_ok  <= (32'(in_idx) < TABLE_DEPTH);
                        r_rank    <= in_rank;
                        r_res_idx <= '0;
                        r_res_q   <= 1'b0;
                        case (in_cmd)
                            CMD_INC: begin
                                r_state <= S_INC;
                            end
                            CMD_CLEAR: begin
                                for (int j = 0; j < TABLE_DEPTH; j++) begin
                                    if (CNT_W'(j) < used_n) begin
                                        r_va[j] <= 1'b0;
                                        r_vb[j] <= 1'b0;
                                    end
                                end
                                r_state <= S_FIN;
                            end
                            CMD_QUERY: begin
                                r_res_q    <= 1'b1;
                                r_marks    <= '0;
                                r_ref      <= SCORE_MAX;
                                r_ref_ok   <= 1'b1;
                                r_has_best <= 1'b0;
                                r_round    <= '0;
                                r_rd_idx   <= '0;
                                r_pv       <= 1'b0;
                                r_state    <= (in_rank == '0) ? S_FIN : S_SCAN;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_INC: begin
                    if (inc_do) begin
                        if (r_sel) begin
                            r_vb[r_pidx] <= 1'b1;
                        end else begin
                            r_va[r_pidx] <= 1'b1;
                        end
                    end
                    r_state <= S_FIN;
                end
                S_SCAN: begin
                    if (end_round) begin
                        r_marks[win] <= 1'b1;
                        r_ref        <= r_best;
                        r_ref_ok     <= r_has_best;
                        r_has_best   <= 1'b0;
                        r_rd_idx     <= '0;
                        r_pv         <= 1'b0;
                        r_round      <= n_round;
                        if (n_round == r_rank) begin
                            r_res_idx <= ENTRY_W'(win);
                            r_state   <= S_FIN;
                        end
                    end else begin
                        if (cand && (!r_has_best || (cur_s > r_best))) begin
                            r_best     <= cur_s;
                            r_best_idx <= r_pidx;
                            r_has_best <= 1'b1;
                        end
                        if (issue) begin
                            r_pidx   <= r_rd_idx[IDX_W-1:0];
                            r_rd_idx <= r_rd_idx + CNT_W'(1);
                            r_pv     <= 1'b1;
                        end else begin
                            r_pv <= 1'b0;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= r_res_idx;
                        r_oq     <= r_res_q;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = M_TDATA_W'(r_oidx);
    assign o_m_tuser  = r_oq;

endmodule

// ===== rtl/stsel_ram.sv =====
// ----------------------------------------------------------------------------
// Score table rank select: score RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stsel_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 14
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stsel_checker.sv =====
// ----------------------------------------------------------------------------
// Score table rank select: port checker
// Watches the ports of the core over time; bound to the core below.
// ----------------------------------------------------------------------------
`include "score_table_rank_select_core_defines.svh"

module stsel_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          o_s_tready,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [stsel_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  logic                          o_m_tuser
);

    import stsel_pkg::*;

    `STSEL_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    `STSEL_ASSERT(a_data_hold, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
    `STSEL_ASSERT(a_non_query_zero, o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
    `STSEL_ASSERT(a_one_at_a_time, i_s_tvalid && o_s_tready |=> !o_s_tready)
    `STSEL_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_m_tvalid)

endmodule

bind score_table_rank_select_core stsel_checker u_stsel_checker (.*);
